// ===== hdl/greedy_nearest_neighbor_ordering_macros.svh =====
// Assertion macros for the greedy nearest-neighbour ordering block.
// Used by the RTL files that carry concurrent assertions; needs clk_i and rst_ni.
`ifndef GREEDY_NEAREST_NEIGHBOR_ORDERING_MACROS_SVH
`define GREEDY_NEAREST_NEIGHBOR_ORDERING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GNNO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GNNO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/gnno_pkg.sv =====
// Package for the greedy nearest-neighbour ordering block.
// Holds word types, cell and search structs, constants and the state enum.
`default_nettype none
package gnno_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SCAN_LEN   = MAX_POINTS + 2;
  localparam int SCAN_W     = $clog2(SCAN_LEN);
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DIST_W     = SQ_W + 1;

  localparam logic CFG_DATUM_X = 1'b0;
  localparam logic CFG_DATUM_Z = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_z;
    logic   final_point;
  } in_word_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_z;
    logic   end_of_run;
    logic   points_dropped;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    logic             taken;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           z;
  } cell_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           z;
  } best_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_MARK
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/gnno_cell.sv =====
// One cell of the point ring: holds a stored point with its flags.
// Depends on gnno_pkg.
`default_nettype none
module gnno_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          shift_i,
  input  wire                          clear_i,
  input  wire                          mark_i,
  input  wire  [gnno_pkg::IDX_W-1:0]   mark_idx_i,
  input  gnno_pkg::cell_t              cell_i,
  output gnno_pkg::cell_t              cell_o
);

  logic valid_q, valid_d, taken_q, taken_d;
  logic [gnno_pkg::IDX_W-1:0] idx_q;
  gnno_pkg::coord_t x_q, z_q;

  always_comb begin
    valid_d = valid_q;
    taken_d = taken_q;
    priority if (clear_i) begin
      valid_d = 1'b0;
      taken_d = 1'b0;
    end else if (shift_i) begin
      valid_d = cell_i.valid;
      taken_d = cell_i.taken;
    end else if (mark_i && valid_q && idx_q == mark_idx_i) begin
      taken_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      taken_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      taken_q <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      idx_q <= cell_i.idx;
      x_q   <= cell_i.x;
      z_q   <= cell_i.z;
    end
  end

  assign cell_o = '{valid: valid_q, taken: taken_q, idx: idx_q, x: x_q, z: z_q};

endmodule
`default_nettype wire

// ===== hdl/gnno_dist.sv =====
// Distance pipeline at the ring head: difference, square, then sum and best-so-far.
// Depends on gnno_pkg.
`default_nettype none
module gnno_dist (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire                en_i,
  input  gnno_pkg::cell_t    head_i,
  input  gnno_pkg::coord_t   target_x_i,
  input  gnno_pkg::coord_t   target_z_i,
  output gnno_pkg::best_t    best_o
);

  logic                              v1_q, v2_q;
  logic signed [gnno_pkg::DIFF_W-1:0] dx_q, dz_q;
  logic [gnno_pkg::IDX_W-1:0]        idx1_q, idx2_q;
  gnno_pkg::coord_t                  x1_q, z1_q, x2_q, z2_q;
  logic signed [gnno_pkg::SQ_W-1:0]  sqx_q, sqz_q;
  logic [gnno_pkg::DIST_W-1:0]       sq_sum, best_d_q, best_d_d;
  logic                              found_q, found_d, base_found, better;
  logic [gnno_pkg::IDX_W-1:0]        best_idx_q, best_idx_d;
  gnno_pkg::coord_t                  best_x_q, best_x_d, best_z_q, best_z_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q    <= en_i && head_i.valid && !head_i.taken;
      v2_q    <= v1_q;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= {head_i.x[gnno_pkg::COORD_W-1], head_i.x}
              - {target_x_i[gnno_pkg::COORD_W-1], target_x_i};
    dz_q     <= {head_i.z[gnno_pkg::COORD_W-1], head_i.z}
              - {target_z_i[gnno_pkg::COORD_W-1], target_z_i};
    idx1_q   <= head_i.idx;
    x1_q     <= head_i.x;
    z1_q     <= head_i.z;
    sqx_q    <= dx_q * dx_q;
    sqz_q    <= dz_q * dz_q;
    idx2_q   <= idx1_q;
    x2_q     <= x1_q;
    z2_q     <= z1_q;
    best_d_q   <= best_d_d;
    best_idx_q <= best_idx_d;
    best_x_q   <= best_x_d;
    best_z_q   <= best_z_d;
  end

  always_comb begin
    sq_sum = {1'b0, sqx_q} + {1'b0, sqz_q};
    base_found = found_q && !start_i;
    better = !base_found || sq_sum < best_d_q
             || (sq_sum == best_d_q && idx2_q < best_idx_q);
    found_d    = base_found;
    best_d_d   = best_d_q;
    best_idx_d = best_idx_q;
    best_x_d   = best_x_q;
    best_z_d   = best_z_q;
    if (v2_q && better) begin
      found_d    = 1'b1;
      best_d_d   = sq_sum;
      best_idx_d = idx2_q;
      best_x_d   = x2_q;
      best_z_d   = z2_q;
    end
  end

  assign best_o = '{found: found_q, idx: best_idx_q, x: best_x_q, z: best_z_q};

endmodule
`default_nettype wire

// ===== hdl/greedy_nearest_neighbor_ordering.sv =====
// Top level of the greedy nearest-neighbour ordering block.
// Depends on gnno_pkg, gnno_cell, gnno_dist and the assertion macro header.
//
// Usage: points arrive on the input channel (valid/ready), one word each,
// and are held in a ring of MAX_POINTS cells in load order. The word with
// final_point set closes the set; further points beyond capacity are dropped
// and points_dropped is set on every result of that run. Input ready is high
// only while loading. After the final word the block emits every stored
// point once, on the output channel, in greedy nearest-neighbour order,
// starting from the datum held in the configuration registers (index 0 is
// datum_x, index 1 is datum_z, written at any edge with cfg_we_i high).
// For each result the whole ring rotates past one distance pipeline of
// three stages, then a mark step marks and emits the winner. The output
// register holds a word until it is taken; a stalled receiver holds the
// search in its mark step. Reset empties the ring, clears both datum
// registers and leaves the block ready to load.
`default_nettype none
`include "greedy_nearest_neighbor_ordering_macros.svh"
module greedy_nearest_neighbor_ordering (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  gnno_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output gnno_pkg::out_word_t  out_data_o,
  input  wire                  cfg_we_i,
  input  wire                  cfg_idx_i,
  input  wire  [gnno_pkg::COORD_W-1:0] cfg_data_i
);

  localparam int N = gnno_pkg::MAX_POINTS;

  gnno_pkg::state_e state_q, state_d;
  gnno_pkg::coord_t datum_x_q, datum_z_q, target_x_q, target_z_q;
  logic [gnno_pkg::CNT_W-1:0]  count_q, count_d, emitted_q, emitted_d;
  logic [gnno_pkg::SCAN_W-1:0] scan_q, scan_d;
  logic overflow_q, overflow_d, out_valid_q, out_valid_d;
  gnno_pkg::out_word_t out_q;
  gnno_pkg::cell_t ring [N];
  gnno_pkg::cell_t feed, new_cell;
  gnno_pkg::best_t best;
  logic in_acc, store, rotate, shift, slot_free, emit, last_emit, start;

  assign in_acc    = in_valid_i && in_ready_o;
  assign store     = in_acc && count_q < gnno_pkg::CNT_W'(N);
  assign slot_free = !out_valid_q || out_ready_i;
  assign last_emit = (emitted_q + 1'b1) == count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gnno_pkg::S_LOAD: if (in_acc && in_data_i.final_point) state_d = gnno_pkg::S_SCAN;
      gnno_pkg::S_SCAN: if (scan_q == gnno_pkg::SCAN_W'(gnno_pkg::SCAN_LEN - 1)) begin
        state_d = gnno_pkg::S_MARK;
      end
      gnno_pkg::S_MARK: if (slot_free) begin
        state_d = last_emit ? gnno_pkg::S_LOAD : gnno_pkg::S_SCAN;
      end
      default: state_d = gnno_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o = state_q == gnno_pkg::S_LOAD;
    rotate     = state_q == gnno_pkg::S_SCAN && scan_q < gnno_pkg::SCAN_W'(N);
    start      = state_q == gnno_pkg::S_SCAN && scan_q == '0;
    emit       = state_q == gnno_pkg::S_MARK && slot_free;
    shift      = store || rotate;
    count_d    = store ? count_q + 1'b1 : count_q;
    overflow_d = overflow_q || (in_acc && !store);
    emitted_d  = emitted_q;
    scan_d     = state_q == gnno_pkg::S_SCAN ? scan_q + 1'b1 : '0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d = 1'b1;
      emitted_d   = emitted_q + 1'b1;
      if (last_emit) begin
        count_d    = '0;
        overflow_d = 1'b0;
        emitted_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gnno_pkg::S_LOAD;
      count_q     <= '0;
      emitted_q   <= '0;
      scan_q      <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
      datum_x_q   <= '0;
      datum_z_q   <= '0;
      target_x_q  <= '0;
      target_z_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      emitted_q   <= emitted_d;
      scan_q      <= scan_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == gnno_pkg::CFG_DATUM_X) datum_x_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == gnno_pkg::CFG_DATUM_Z) datum_z_q <= cfg_data_i;
      if (in_acc && in_data_i.final_point) begin
        target_x_q <= datum_x_q;
        target_z_q <= datum_z_q;
      end else if (emit) begin
        target_x_q <= best.x;
        target_z_q <= best.z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= '{out_x: best.x, out_z: best.z, end_of_run: last_emit,
                 points_dropped: overflow_q};
    end
  end

  assign new_cell = '{valid: 1'b1, taken: 1'b0, idx: count_q[gnno_pkg::IDX_W-1:0],
                      x: in_data_i.point_x, z: in_data_i.point_z};
  assign feed = store ? new_cell : ring[N-1];

  for (genvar i = 0; i < N; i++) begin : g_ring
    gnno_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .clear_i    (emit && last_emit),
      .mark_i     (emit),
      .mark_idx_i (best.idx),
      .cell_i     ((i == 0) ? feed : ring[(i == 0) ? 0 : i - 1]),
      .cell_o     (ring[i])
    );
  end

  gnno_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .en_i       (rotate),
    .head_i     (ring[N-1]),
    .target_x_i (target_x_q),
    .target_z_i (target_z_q),
    .best_o     (best)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GNNO_ASSERT_IMPL(a_mark_has_winner, state_q == gnno_pkg::S_MARK, best.found)
  `GNNO_ASSERT_IMPL(a_emitted_below_count,
    state_q == gnno_pkg::S_SCAN || state_q == gnno_pkg::S_MARK, emitted_q < count_q)
  `GNNO_ASSERT_IMPL(a_load_starts_fresh, state_q == gnno_pkg::S_LOAD, emitted_q == '0)
  `GNNO_ASSERT_NEXT(a_last_returns_to_load, emit && last_emit,
    state_q == gnno_pkg::S_LOAD && count_q == '0)

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for greedy_nearest_neighbor_ordering: loads point sets,
// predicts the greedy nearest-neighbour emission order and checks every result word.
// Depends on gnno_pkg and the top-level RTL only.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  gnno_pkg::in_word_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  gnno_pkg::out_word_t out_data_o;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [gnno_pkg::COORD_W-1:0] cfg_data_i;

  greedy_nearest_neighbor_ordering dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  typedef struct {
    gnno_pkg::in_word_t  w;
    bit                  typed;
    gnno_pkg::out_word_t res;
  } row_t;

  gnno_pkg::coord_t    held_x [gnno_pkg::MAX_POINTS];
  gnno_pkg::coord_t    held_z [gnno_pkg::MAX_POINTS];
  int                  held_cnt;
  bit                  overflow;
  gnno_pkg::coord_t    datum_x, datum_z;
  gnno_pkg::out_word_t run_q[$];
  gnno_pkg::out_word_t expected_q[$];
  int                  errors = 0;
  int                  send_idle, recv_idle;
  int                  quiet_cycles = 0;

  function automatic longint sq_dist(gnno_pkg::coord_t ax, gnno_pkg::coord_t az,
                                     gnno_pkg::coord_t bx, gnno_pkg::coord_t bz);
    longint dx, dz;
    dx = longint'(ax) - longint'(bx);
    dz = longint'(az) - longint'(bz);
    return dx * dx + dz * dz;
  endfunction

  function automatic void order_points(gnno_pkg::in_word_t w);
    bit                  used [gnno_pkg::MAX_POINTS];
    gnno_pkg::coord_t    tx, tz;
    longint              d, best_d;
    int                  best;
    gnno_pkg::out_word_t o;
    run_q.delete();
    if (held_cnt < gnno_pkg::MAX_POINTS) begin
      held_x[held_cnt] = w.point_x;
      held_z[held_cnt] = w.point_z;
      held_cnt++;
    end else begin
      overflow = 1'b1;
    end
    if (!w.final_point) return;
    foreach (used[i]) used[i] = 1'b0;
    tx = datum_x;
    tz = datum_z;
    for (int k = 0; k < held_cnt; k++) begin
      best = -1;
      best_d = 0;
      for (int i = 0; i < held_cnt; i++) begin
        if (used[i]) continue;
        d = sq_dist(tx, tz, held_x[i], held_z[i]);
        if (best < 0 || d < best_d) begin
          best = i;
          best_d = d;
        end
      end
      used[best] = 1'b1;
      tx = held_x[best];
      tz = held_z[best];
      o.out_x = tx;
      o.out_z = tz;
      o.end_of_run = (k + 1 == held_cnt);
      o.points_dropped = overflow;
      run_q = {run_q, o};
    end
    held_cnt = 0;
    overflow = 1'b0;
  endfunction

  task automatic send_word(gnno_pkg::in_word_t w, bit typed, gnno_pkg::out_word_t res);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    order_points(w);
    if (typed) expected_q = {expected_q, res};
    else expected_q = {expected_q, run_q};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (3 * (gnno_pkg::MAX_POINTS + 3)) @(posedge clk_i);
  endtask

  task automatic write_datum(gnno_pkg::coord_t vx, gnno_pkg::coord_t vz);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= gnno_pkg::CFG_DATUM_X;
    cfg_data_i <= vx;
    @(posedge clk_i);
    cfg_idx_i  <= gnno_pkg::CFG_DATUM_Z;
    cfg_data_i <= vz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    datum_x = vx;
    datum_z = vz;
  endtask

  function automatic gnno_pkg::coord_t rand_coord();
    if ($urandom_range(3) == 0) return gnno_pkg::coord_t'($signed($urandom_range(8)) - 4);
    return gnno_pkg::coord_t'($urandom);
  endfunction

  function automatic row_t mk(int x, int z, bit fin, bit typed);
    row_t r;
    r.w.point_x = gnno_pkg::coord_t'(x);
    r.w.point_z = gnno_pkg::coord_t'(z);
    r.w.final_point = fin;
    r.typed = typed;
    r.res.out_x = gnno_pkg::coord_t'(x);
    r.res.out_z = gnno_pkg::coord_t'(z);
    r.res.end_of_run = 1'b1;
    r.res.points_dropped = 1'b0;
    return r;
  endfunction

  // A word leaving the block must match the oldest prediction.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: expected nothing actual %p", $realtime, out_data_o);
        errors++;
      end else begin
        if (out_data_o !== expected_q[0]) begin
          $display("%0t: expected %p actual %p", $realtime, expected_q[0], out_data_o);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t                rows[$];
    gnno_pkg::out_word_t none;
    gnno_pkg::in_word_t  w;
    int                  items, set_len;
    none = '0;
    send_idle = 0;
    recv_idle = 0;
    held_cnt = 0;
    overflow = 1'b0;
    datum_x = '0;
    datum_z = '0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= gnno_pkg::CFG_DATUM_X;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{mk(24'h7FFFFF, 24'h7FFFFF, 1, 1), mk(24'h800000, 24'h800000, 1, 1),
             mk(0, 0, 1, 1), mk(24'h7FFFFF, 24'h800000, 1, 1),
             mk(24'h800000, 24'h7FFFFF, 1, 1),
             mk(1, 0, 0, 0), mk(-1, 0, 0, 0), mk(0, 1, 0, 0), mk(0, -1, 1, 0),
             mk(5, 5, 0, 0), mk(5, 5, 0, 0), mk(-3, 2, 1, 0),
             mk(24'h7FFFFF, 24'h800000, 0, 0), mk(24'h800000, 24'h7FFFFF, 0, 0),
             mk(24'h800000, 24'h800000, 0, 0), mk(24'h7FFFFF, 24'h7FFFFF, 1, 0),
             mk(24'h555555, 24'hAAAAAA, 0, 0), mk(24'hAAAAAA, 24'h555555, 1, 0)};
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    for (int p = 0; p < 3; p++) begin
      drain();
      send_idle = (p == 0) ? 34 : (p == 1) ? 88 : 0;
      recv_idle = (p == 0) ? 88 : (p == 1) ? 34 : 0;
      case (p)
        0: begin
          write_datum(24'h7FFFFF, 24'h800000);
        end
        1: begin
          write_datum(24'h800000, 24'h7FFFFF);
        end
        default: begin
          write_datum(rand_coord(), rand_coord());
        end
      endcase
      items = 0;
      // One oversized set per phase so that the store overflows.
      while (items < 100) begin
        set_len = (items == 0) ? $urandom_range(gnno_pkg::MAX_POINTS + 1,
                                                gnno_pkg::MAX_POINTS + 2)
                               : $urandom_range(1, 8);
        for (int k = 0; k < set_len; k++) begin
          w.point_x = rand_coord();
          w.point_z = rand_coord();
          w.final_point = (k == set_len - 1);
          send_word(w, 1'b0, none);
        end
        items += set_len;
      end
    end

    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (2 * (gnno_pkg::MAX_POINTS + 3)) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
